// ----- rtl/i2ce_pkg.sv -----
// Shared types and constants for the I2C EEPROM slave.
package i2ce_pkg;

  localparam int unsigned MemBytesDef   = 16;
  localparam logic [15:0] WriteTicksRst = 16'd4000;

  localparam logic [1:0] EvSclEdge = 2'd0;
  localparam logic [1:0] EvSdaEdge = 2'd1;
  localparam logic [1:0] EvTick    = 2'd2;

  localparam logic [3:0] PhIdle    = 4'd0;
  localparam logic [3:0] PhStart   = 4'd1;
  localparam logic [3:0] PhRxCmd   = 4'd2;
  localparam logic [3:0] PhAckCmd  = 4'd3;
  localparam logic [3:0] PhRxAddr  = 4'd4;
  localparam logic [3:0] PhAckAddr = 4'd5;
  localparam logic [3:0] PhRxData  = 4'd6;
  localparam logic [3:0] PhAckWr   = 4'd7;
  localparam logic [3:0] PhWrPend  = 4'd8;
  localparam logic [3:0] PhAckRd   = 4'd9;
  localparam logic [3:0] PhTxData  = 4'd10;

  localparam logic [7:0] CmdMask = 8'hF0;
  localparam logic [7:0] CmdId   = 8'hA0;
  localparam logic [3:0] BitsPerByte = 4'd8;

  typedef struct packed {
    logic [1:0] cmd;
    logic       line_level;
    logic       other_level;
  } event_t;

  typedef struct packed {
    logic [3:0] phase;
    logic       busy_res;
    logic       sda_release;
  } result_t;

  typedef struct packed {
    logic       we;
    logic [7:0] wdata;
  } mem_wr_t;

endpackage

// ----- rtl/i2ce_mem.sv -----
// Byte store with registered read, write forwarding and per-entry valid bits.
module i2ce_mem #(
  parameter int unsigned MEM_BYTES = i2ce_pkg::MemBytesDef,
  parameter int unsigned AW        = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  i2ce_pkg::mem_wr_t wr_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic [7:0]        rd_data_o
);
  import i2ce_pkg::*;

  logic [7:0]           mem_q [MEM_BYTES];
  logic [MEM_BYTES-1:0] valid_q;
  logic [7:0]           rd_q;
  logic                 rd_vld_q;
  logic                 fwd;

  assign fwd = wr_i.we && (wr_addr_i == rd_addr_i);

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_addr_i] <= wr_i.wdata;
    end
    rd_q <= fwd ? wr_i.wdata : mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.we) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      rd_vld_q <= fwd || valid_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : 8'd0;

endmodule

// ----- rtl/i2ce_core.sv -----
// Bus phase state machine, shift register, address and busy countdown.
module i2ce_core #(
  parameter int unsigned MEM_BYTES = i2ce_pkg::MemBytesDef,
  parameter int unsigned AW        = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  i2ce_pkg::event_t  ev_i,
  input  logic [15:0]       write_ticks_i,
  input  logic [7:0]        rd_data_i,
  output logic [AW-1:0]     rd_addr_o,
  output i2ce_pkg::mem_wr_t wr_o,
  output logic [AW-1:0]     wr_addr_o,
  output i2ce_pkg::result_t res_o
);
  import i2ce_pkg::*;

  typedef logic [AW-1:0] mod_tab_t [256];

  function automatic mod_tab_t build_mod_tab();
    mod_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = AW'(i % MEM_BYTES);
    end
    return t;
  endfunction

  localparam mod_tab_t ModTab = build_mod_tab();

  logic [3:0]    phase_q, phase_d;
  logic [3:0]    cnt_q, cnt_d;
  logic [7:0]    shift_q, shift_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [15:0]   busy_q, busy_d;
  logic          sda_q, sda_d;
  logic          commit;
  logic [3:0]    cnt_inc, cnt_dec;
  logic [7:0]    shift_in;
  logic [AW-1:0] addr_inc;

  assign cnt_inc  = cnt_q + 4'd1;
  assign cnt_dec  = cnt_q - 4'd1;
  assign shift_in = {shift_q[6:0], ev_i.other_level};
  assign addr_inc = (addr_q == AW'(MEM_BYTES - 1)) ? '0 : addr_q + AW'(1);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    addr_d  = addr_q;
    busy_d  = busy_q;
    sda_d   = sda_q;
    commit  = 1'b0;
    if (en_i) begin
      unique case (ev_i.cmd)
        EvSclEdge: begin
          if (!ev_i.line_level) begin
            unique case (phase_q)
              PhIdle: sda_d = 1'b1;
              PhStart: begin
                sda_d   = 1'b1;
                phase_d = PhRxCmd;
              end
              PhRxCmd: begin
                cnt_d   = cnt_inc;
                shift_d = shift_in;
                if (cnt_inc == BitsPerByte) begin
                  if ((shift_in & CmdMask) == CmdId) begin
                    phase_d = PhAckCmd;
                    sda_d   = 1'b0;
                  end else begin
                    phase_d = PhIdle;
                  end
                end
              end
              PhAckCmd: begin
                sda_d = 1'b1;
                if (shift_q[0]) begin
                  phase_d = PhTxData;
                  cnt_d   = BitsPerByte - 4'd1;
                  shift_d = rd_data_i;
                  sda_d   = rd_data_i[7];
                end else begin
                  phase_d = PhRxAddr;
                  cnt_d   = 4'd0;
                  shift_d = 8'd0;
                end
              end
              PhRxAddr: begin
                cnt_d   = cnt_inc;
                shift_d = shift_in;
                if (cnt_inc == BitsPerByte) begin
                  sda_d   = 1'b0;
                  phase_d = PhAckAddr;
                  addr_d  = ModTab[shift_in];
                end
              end
              PhAckAddr: begin
                sda_d   = 1'b1;
                phase_d = PhRxData;
                cnt_d   = 4'd0;
                shift_d = 8'd0;
              end
              PhRxData: begin
                cnt_d   = cnt_inc;
                shift_d = shift_in;
                if (cnt_inc == BitsPerByte) begin
                  sda_d   = 1'b0;
                  phase_d = PhAckWr;
                end
              end
              PhAckWr: begin
                sda_d   = 1'b1;
                phase_d = PhWrPend;
              end
              PhWrPend: begin
                shift_d = {7'd0, ev_i.other_level};
                cnt_d   = 4'd1;
                phase_d = PhRxData;
              end
              PhTxData: begin
                if (cnt_q == 4'd0) begin
                  sda_d   = 1'b1;
                  addr_d  = addr_inc;
                  phase_d = PhAckRd;
                end else begin
                  cnt_d = cnt_dec;
                  sda_d = cnt_dec[3] ? 1'b0 : shift_q[cnt_dec[2:0]];
                end
              end
              PhAckRd: begin
                if (!ev_i.other_level) begin
                  phase_d = PhTxData;
                  cnt_d   = BitsPerByte - 4'd1;
                  shift_d = rd_data_i;
                  sda_d   = rd_data_i[7];
                end else begin
                  phase_d = PhIdle;
                end
              end
              default: begin
                sda_d   = 1'b1;
                phase_d = PhIdle;
              end
            endcase
          end
        end
        EvSdaEdge: begin
          if (ev_i.other_level) begin
            if (ev_i.line_level) begin
              if (phase_q == PhWrPend) begin
                commit = 1'b1;
                busy_d = write_ticks_i;
              end
              phase_d = PhIdle;
            end else if (busy_q == 16'd0) begin
              phase_d = PhStart;
              cnt_d   = 4'd0;
              shift_d = 8'd0;
            end
          end
        end
        EvTick: begin
          if (busy_q != 16'd0) begin
            busy_d = busy_q - 16'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      cnt_q   <= 4'd0;
      shift_q <= 8'd0;
      addr_q  <= '0;
      busy_q  <= 16'd0;
      sda_q   <= 1'b1;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
      addr_q  <= addr_d;
      busy_q  <= busy_d;
      sda_q   <= sda_d;
    end
  end

  assign rd_addr_o = addr_d;
  assign wr_addr_o = addr_q;
  assign wr_o.we    = commit;
  assign wr_o.wdata = shift_q;

  assign res_o.phase       = phase_d;
  assign res_o.busy_res    = (busy_d != 16'd0);
  assign res_o.sda_release = sda_d;

endmodule

// ----- rtl/i2c_eeprom_slave_unit.sv -----
// Top level of the I2C EEPROM slave: input register, core, byte store, result register.
//
// Each transfer on the input stream is one bus event (SCL edge, SDA edge or time tick)
// and yields exactly one result transfer with the SDA drive, busy flag and bus phase
// after that event. One event is taken per clock cycle while the result stream is not
// stalled; a result passes through the input register and the result register around
// the core's state update. The byte store reads through a register that follows
// the next address, so a read byte is ready when the next event needs it. The store
// reads as zero after reset. write_ticks is written through cfg_we_i/cfg_wdata_i; the
// user must write it only while no events are in flight, which the block does not enforce.
module i2c_eeprom_slave_unit #(
  parameter int unsigned MEM_BYTES = i2ce_pkg::MemBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,        // write_ticks
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,     // [0] line_level, [1] other_level
  input  logic [1:0]  s_axis_tuser_i,     // [1:0] cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o      // [0] sda_release, [1] busy_res, [5:2] phase
);
  import i2ce_pkg::*;

  localparam int unsigned AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;

  logic          in_vq;
  event_t        ev_q;
  logic          out_vq;
  result_t       res_q;
  result_t       res_d;
  logic          advance;
  logic [15:0]   write_ticks_q;
  logic [7:0]    rd_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  mem_wr_t       mem_wr;

  assign advance         = in_vq && (!out_vq || m_axis_tready_i);
  assign s_axis_tready_o = !in_vq || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_ticks_q <= WriteTicksRst;
      in_vq         <= 1'b0;
      out_vq        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        write_ticks_q <= cfg_wdata_i;
      end
      if (s_axis_tready_o) begin
        in_vq <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_vq <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vq <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      ev_q.cmd         <= s_axis_tuser_i;
      ev_q.line_level  <= s_axis_tdata_i[0];
      ev_q.other_level <= s_axis_tdata_i[1];
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  i2ce_core #(
    .MEM_BYTES(MEM_BYTES),
    .AW       (AW)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .ev_i         (ev_q),
    .write_ticks_i(write_ticks_q),
    .rd_data_i    (rd_data),
    .rd_addr_o    (rd_addr),
    .wr_o         (mem_wr),
    .wr_addr_o    (wr_addr),
    .res_o        (res_d)
  );

  i2ce_mem #(
    .MEM_BYTES(MEM_BYTES),
    .AW       (AW)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (mem_wr),
    .wr_addr_i(wr_addr),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  assign m_axis_tvalid_o = out_vq;
  assign m_axis_tdata_o  = {2'b00, res_q};

endmodule

// ----- rtl/i2ce_checker.sv -----
// Port-level checks for the I2C EEPROM slave, bound to the top level.
module i2ce_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o
);
  import i2ce_pkg::*;

  logic       out_xfer;
  logic [3:0] ph;

  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;
  assign ph       = m_axis_tdata_o[5:2];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result transfer dropped while stalled");

  a_ack_drives_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && (ph == PhAckCmd || ph == PhAckAddr || ph == PhAckWr)
      |-> !m_axis_tdata_o[0])
    else $error("SDA released during slave ack");

  a_ack_rd_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && ph == PhAckRd |-> m_axis_tdata_o[0])
    else $error("SDA driven during master ack");

  a_start_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && ph == PhStart |-> !m_axis_tdata_o[1])
    else $error("start accepted while busy");

endmodule

bind i2c_eeprom_slave_unit i2ce_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);
